// File: sv/quoted_word_splitter_unit_assert.svh
// assertion macros for the quoted word splitter
// used by the top level only, no other dependencies
`ifndef QUOTED_WORD_SPLITTER_UNIT_ASSERT_SVH
`define QUOTED_WORD_SPLITTER_UNIT_ASSERT_SVH

// same-cycle implication, gated by reset
`define QWS_ASSERT_IMP(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error("qws assertion failed");

// next-cycle implication, gated by reset
`define QWS_ASSERT_NXT(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error("qws assertion failed");

`endif

// File: sv/qws_pkg.sv
// shared types, codes and constants of the quoted word splitter
// no dependencies
package qws_pkg;

    localparam int COUNT_BITS   = 16;
    localparam int SHOW_BITS    = 16;
    localparam int CMD_DEPTH    = 4;
    localparam int CMD_PTR_BITS = $clog2(CMD_DEPTH);
    localparam int CMD_CNT_BITS = $clog2(CMD_DEPTH + 1);

    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_SQUOTE = 8'h27;

    typedef enum logic [1:0] {
        MODE_IDLE   = 2'd0,
        MODE_QUOTED = 2'd1,
        MODE_PLAIN  = 2'd2
    } mode_t;

    typedef enum logic [1:0] {
        EV_BYTE     = 2'd0,
        EV_DONE     = 2'd1,
        EV_WITHDRAW = 2'd2,
        EV_END      = 2'd3
    } ev_t;

    // one queued command: first result, plus an optional string-done result
    typedef struct packed {
        ev_t                  ev;
        logic [7:0]           data;
        logic [SHOW_BITS-1:0] count;
        logic                 has_end;
    } cmd_t;

    typedef struct packed {
        mode_t                 mode;
        logic [COUNT_BITS-1:0] words;
    } front_stat_t;

    typedef struct packed {
        logic full;
        logic empty;
    } fifo_stat_t;

    // count as shown on the result port, capped at the port width
    function automatic logic [SHOW_BITS-1:0] show_count(input logic [COUNT_BITS-1:0] c);
        logic [32:0] wide;
        logic [32:0] cap;
        wide = 33'(c);
        cap  = 33'({SHOW_BITS{1'b1}});
        if (wide > cap)
        begin
            return {SHOW_BITS{1'b1}};
        end
        return wide[SHOW_BITS-1:0];
    endfunction

endpackage

// File: sv/qws_front.sv
// front part: accepts string bytes, tracks word state, builds commands
// depends on qws_pkg
module qws_front import qws_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    input  logic [7:0]  in_byte,
    output logic        full,
    input  logic        cmd_full,
    output logic        cmd_push,
    output cmd_t        cmd,
    output front_stat_t stat
);

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

    mode_t                 mode_reg, mode_next;
    logic                  quote_kind_reg, quote_kind_next;
    logic [COUNT_BITS-1:0] words_reg, words_next;
    logic [COUNT_BITS-1:0] words_inc;
    logic                  accept;
    logic                  is_nul, is_blank, is_quote;
    logic [7:0]            closer;

    assign full     = cmd_full;
    assign accept   = push && !cmd_full;
    assign is_nul   = (in_byte == CH_NUL);
    assign is_blank = in_byte inside {CH_SPACE, CH_TAB};
    assign is_quote = in_byte inside {CH_SQUOTE, CH_DQUOTE};
    assign closer   = quote_kind_reg ? CH_DQUOTE : CH_SQUOTE;
    assign words_inc = (words_reg == COUNT_MAX) ? words_reg : words_reg + COUNT_BITS'(1);

    assign stat.mode  = mode_reg;
    assign stat.words = words_reg;

    // next state
    always_comb
    begin
        mode_next       = mode_reg;
        quote_kind_next = quote_kind_reg;
        words_next      = words_reg;
        if (accept)
        begin
            case (mode_reg)
                MODE_QUOTED:
                begin
                    if (!is_nul && in_byte == closer)
                    begin
                        words_next = words_inc;
                        mode_next  = MODE_IDLE;
                    end
                end
                MODE_PLAIN:
                begin
                    if (is_nul || is_blank)
                    begin
                        words_next = words_inc;
                        mode_next  = MODE_IDLE;
                    end
                end
                default:
                begin
                    if (!is_nul && !is_blank)
                    begin
                        if (is_quote)
                        begin
                            quote_kind_next = (in_byte == CH_DQUOTE);
                            mode_next       = MODE_QUOTED;
                        end
                        else
                        begin
                            mode_next = MODE_PLAIN;
                        end
                    end
                    else
                    begin
                        mode_next = MODE_IDLE;
                    end
                end
            endcase
            // end of string returns everything to reset
            if (is_nul)
            begin
                mode_next       = MODE_IDLE;
                quote_kind_next = 1'b0;
                words_next      = '0;
            end
        end
    end

    // command outputs
    always_comb
    begin
        cmd_push    = 1'b0;
        cmd.ev      = EV_BYTE;
        cmd.data    = in_byte;
        cmd.count   = show_count(words_reg);
        cmd.has_end = 1'b0;
        case (mode_reg)
            MODE_QUOTED:
            begin
                cmd_push = accept;
                if (is_nul)
                begin
                    cmd.ev      = EV_WITHDRAW;
                    cmd.has_end = 1'b1;
                end
                else if (in_byte == closer)
                begin
                    cmd.ev    = EV_DONE;
                    cmd.count = show_count(words_inc);
                end
            end
            MODE_PLAIN:
            begin
                cmd_push = accept;
                if (is_nul || is_blank)
                begin
                    cmd.ev      = EV_DONE;
                    cmd.count   = show_count(words_inc);
                    cmd.has_end = is_nul;
                end
            end
            default:
            begin
                if (is_nul)
                begin
                    cmd_push = accept;
                    cmd.ev   = EV_END;
                end
                else if (!is_blank && !is_quote)
                begin
                    cmd_push = accept;
                end
            end
        endcase
        if (cmd.ev != EV_BYTE)
        begin
            cmd.data = 8'h00;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg       <= MODE_IDLE;
            quote_kind_reg <= 1'b0;
            words_reg      <= '0;
        end
        else
        begin
            mode_reg       <= mode_next;
            quote_kind_reg <= quote_kind_next;
            words_reg      <= words_next;
        end
    end

endmodule

// File: sv/qws_cmd_fifo.sv
// short command queue between front and back parts
// depends on qws_pkg
module qws_cmd_fifo import qws_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       wr,
    input  cmd_t       wr_data,
    input  logic       rd,
    output cmd_t       rd_data,
    output fifo_stat_t stat
);

    localparam logic [CMD_PTR_BITS-1:0] LAST_PTR = CMD_PTR_BITS'(CMD_DEPTH - 1);
    localparam logic [CMD_CNT_BITS-1:0] FULL_CNT = CMD_CNT_BITS'(CMD_DEPTH);

    cmd_t                    slot_reg [CMD_DEPTH];
    logic [CMD_PTR_BITS-1:0] wr_ptr_reg, wr_ptr_next;
    logic [CMD_PTR_BITS-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CMD_CNT_BITS-1:0] cnt_reg, cnt_next;
    logic                    do_wr, do_rd;

    assign stat.full  = (cnt_reg == FULL_CNT);
    assign stat.empty = (cnt_reg == '0);
    assign do_wr      = wr && !stat.full;
    assign do_rd      = rd && !stat.empty;
    assign rd_data    = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + CMD_PTR_BITS'(1);
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + CMD_PTR_BITS'(1);
        end
        if (do_wr && !do_rd)
        begin
            cnt_next = cnt_reg + CMD_CNT_BITS'(1);
        end
        else if (do_rd && !do_wr)
        begin
            cnt_next = cnt_reg - CMD_CNT_BITS'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // payload slots, no reset
    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            slot_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

// File: sv/qws_back.sv
// back part: expands commands into results, holds the output register
// depends on qws_pkg
module qws_back import qws_pkg::*; (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cmd_empty,
    input  cmd_t                 cmd,
    output logic                 cmd_pop,
    input  logic                 pop,
    output logic                 empty,
    output logic [1:0]           event_res,
    output logic [7:0]           word_byte,
    output logic [SHOW_BITS-1:0] word_count,
    output logic                 last_of_run
);

    logic                 valid_reg, valid_next;
    ev_t                  ev_reg, ev_next;
    logic [7:0]           byte_reg, byte_next;
    logic [SHOW_BITS-1:0] count_reg, count_next;
    logic                 last_reg, last_next;
    logic                 pend_reg, pend_next;
    logic [SHOW_BITS-1:0] pend_count_reg, pend_count_next;
    logic                 load;

    // output slot frees when empty or taken this cycle
    assign load = !valid_reg || pop;

    always_comb
    begin
        valid_next      = valid_reg;
        ev_next         = ev_reg;
        byte_next       = byte_reg;
        count_next      = count_reg;
        last_next       = last_reg;
        pend_next       = pend_reg;
        pend_count_next = pend_count_reg;
        cmd_pop         = 1'b0;
        if (load)
        begin
            if (pend_reg)
            begin
                // trailing string done
                valid_next = 1'b1;
                ev_next    = EV_END;
                byte_next  = 8'h00;
                count_next = pend_count_reg;
                last_next  = 1'b1;
                pend_next  = 1'b0;
            end
            else if (!cmd_empty)
            begin
                cmd_pop         = 1'b1;
                valid_next      = 1'b1;
                ev_next         = cmd.ev;
                byte_next       = cmd.data;
                count_next      = cmd.count;
                last_next       = !cmd.has_end;
                pend_next       = cmd.has_end;
                pend_count_next = cmd.count;
            end
            else
            begin
                valid_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            pend_reg  <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            pend_reg  <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ev_reg         <= ev_next;
        byte_reg       <= byte_next;
        count_reg      <= count_next;
        last_reg       <= last_next;
        pend_count_reg <= pend_count_next;
    end

    assign empty       = !valid_reg;
    assign event_res   = ev_reg;
    assign word_byte   = byte_reg;
    assign word_count  = count_reg;
    assign last_of_run = last_reg;

endmodule

// File: sv/quoted_word_splitter_unit.sv
// top level of the quoted word splitter: front, command queue, back
// depends on qws_pkg, qws_front, qws_cmd_fifo, qws_back and the assert header
//
//  channel   | handshake        | payload
//  ----------+------------------+---------------------------------------------
//  input     | push / full      | in_byte
//  result    | empty / pop      | event_res, word_byte, word_count, last_of_run
//
// one byte per cycle while the queue has room: the front updates the word state and
// queues at most one command per byte; the back drains one result per cycle while
// results are popped, so end of string inside a word yields two results from the back
// the four-entry command queue plus the output register absorb result stalls
// reset clears word state, queue pointers and the output valid at once
`include "quoted_word_splitter_unit_assert.svh"

module quoted_word_splitter_unit import qws_pkg::*; (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    output logic                 full,
    input  logic [7:0]           in_byte,
    output logic                 empty,
    input  logic                 pop,
    output logic [1:0]           event_res,
    output logic [7:0]           word_byte,
    output logic [SHOW_BITS-1:0] word_count,
    output logic                 last_of_run
);

    // front to queue
    cmd_t        fq_cmd;
    logic        fq_push;
    front_stat_t front_stat;

    // queue to back
    cmd_t        qb_cmd;
    logic        qb_pop;
    fifo_stat_t  fifo_stat;

    // terminator taken this cycle, and the front back at its reset state
    logic        nul_taken;
    logic        front_clear;

    assign nul_taken   = push && !full && (in_byte == CH_NUL);
    assign front_clear = (front_stat.mode == MODE_IDLE) && (front_stat.words == '0);

    // front classifies bytes and tracks quoting and the word count
    qws_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .in_byte  (in_byte),
        .full     (full),
        .cmd_full (fifo_stat.full),
        .cmd_push (fq_push),
        .cmd      (fq_cmd),
        .stat     (front_stat)
    );

    // decouples byte intake from result backpressure
    qws_cmd_fifo u_cmd_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (fq_push),
        .wr_data (fq_cmd),
        .rd      (qb_pop),
        .rd_data (qb_cmd),
        .stat    (fifo_stat)
    );

    // back turns each command into one or two results
    qws_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd_empty   (fifo_stat.empty),
        .cmd         (qb_cmd),
        .cmd_pop     (qb_pop),
        .pop         (pop),
        .empty       (empty),
        .event_res   (event_res),
        .word_byte   (word_byte),
        .word_count  (word_count),
        .last_of_run (last_of_run)
    );

    // string done always closes the run of its byte
    `QWS_ASSERT_IMP(a_end_is_last, clk, rst_n, !empty && event_res == EV_END, last_of_run)

    // only word bytes carry data
    `QWS_ASSERT_IMP(a_byte_zero, clk, rst_n, !empty && event_res != EV_BYTE, word_byte == 8'h00)

    // back never reads an empty queue
    `QWS_ASSERT_IMP(a_no_underrun, clk, rst_n, qb_pop, !fifo_stat.empty)

    // a terminator clears the parser state
    `QWS_ASSERT_NXT(a_nul_resets, clk, rst_n, nul_taken, front_clear)

endmodule
